/* hdl/hrhp_pkg.sv */
// shared types, codes and method tables for the http request head parser
package hrhp_pkg;

    localparam int unsigned LEN_BITS_DEF = 16;
    localparam int unsigned CFG_W        = 16;
    localparam int unsigned CFG_ADDR_W   = 2;
    localparam int unsigned HELD_W       = 16;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URI     = 3'd1,
        PH_VERSION = 3'd2,
        PH_HEADER  = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_URI     = 3'd1,
        KIND_VERSION = 3'd2,
        KIND_KEY     = 3'd3,
        KIND_VALUE   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_METHOD   = 3'd1,
        EV_URI_END  = 3'd2,
        EV_VER_END  = 3'd3,
        EV_KEY_END  = 3'd4,
        EV_HDR_END  = 3'd5,
        EV_HEAD_END = 3'd6
    } t_event;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_METHOD   = 3'd1,
        ERR_TOO_LONG = 3'd2,
        ERR_NO_COLON = 3'd3,
        ERR_TRAILING = 3'd4
    } t_error;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_METHOD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_URI     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_VERSION = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_HEADER  = 2'd3;

    localparam logic [CFG_W-1:0] RST_MAX_METHOD  = 16'd16;
    localparam logic [CFG_W-1:0] RST_MAX_URI     = 16'd8192;
    localparam logic [CFG_W-1:0] RST_MAX_VERSION = 16'd16;
    localparam logic [CFG_W-1:0] RST_MAX_HEADER  = 16'd8192;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;

    localparam int unsigned NUM_METHODS = 8;

    // CONNECT, DELETE, GET, HEAD, OPTIONS, POST, PUT, TRACE
    localparam logic [2:0] METHOD_LEN [NUM_METHODS] = '{
        3'd7, 3'd6, 3'd3, 3'd4, 3'd7, 3'd4, 3'd3, 3'd5
    };

    typedef struct packed {
        t_kind       data_kind;
        logic [7:0]  data_byte;
        logic [15:0] held_cr_count;
        t_event      event_res;
        logic [2:0]  method_code;
        t_error      error_code;
        t_phase      phase;
    } t_result;

    // character at position pos of method m, first character at pos 0
    function automatic logic [7:0] method_char(logic [2:0] m, logic [2:0] pos);
        logic [63:0] name;
        case (m)
            3'd0:    name = {"CONNECT", 8'h00};
            3'd1:    name = {"DELETE", 16'h0000};
            3'd2:    name = {"GET", 40'h0};
            3'd3:    name = {"HEAD", 32'h0};
            3'd4:    name = {"OPTIONS", 8'h00};
            3'd5:    name = {"POST", 32'h0};
            3'd6:    name = {"PUT", 40'h0};
            3'd7:    name = {"TRACE", 24'h0};
            default: name = '0;
        endcase
        return name[63 - 8 * int'(pos) -: 8];
    endfunction

endpackage

/* hdl/http_request_head_parser_core.sv */
// http request head parser: method match, field streaming, sticky errors
//
// Takes one request byte (or a restart, tuser high) per cycle while s_tready is high and
// produces exactly one result per request. The whole parser step for a byte is one level
// of logic from the parser state to a two-entry output buffer, so the block sustains one
// request per clock while s_tready is high; each result is registered there. The output
// buffer (result register plus skid entry) lets the slave side keep taking requests while
// a result waits; s_tready drops only when both entries are full. There is no clearing
// pass after reset. Limit registers are to be written through the config port only while
// idle, which the block does not enforce, and keep their values over a restart.
module http_request_head_parser_core
    import hrhp_pkg::*;
#(
    parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // in_byte
    input  logic                  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // data_byte, held_cr_count, event_res, method_code, error_code, phase, zero pad
    output logic [39:0]           m_tdata,
    output logic [2:0]            m_tuser    // data_kind
);

    localparam int unsigned CMP_W = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;

    // limits
    logic [CFG_W-1:0] r_max_method, r_max_uri, r_max_version, r_max_header;

    // parser state
    t_phase                r_phase, n_phase;
    logic [LEN_BITS-1:0]   r_tok_len, n_tok_len;
    logic [NUM_METHODS-1:0] r_cands, n_cands;
    logic [LEN_BITS-1:0]   r_pend, n_pend;
    logic                  r_in_value, n_in_value;
    logic                  r_skip_sp, n_skip_sp;
    logic                  r_line_content, n_line_content;
    t_error                r_err, n_err;

    // output buffer
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic       in_fire, out_fire;
    logic [7:0] c;
    logic [CFG_W-1:0] limit;
    logic       len_ok;
    logic       found;
    logic [2:0] found_code;
    logic [LEN_BITS-1:0] tok_inc, pend_inc;
    logic [CMP_W-1:0]    pend_ext;
    t_result    res;

    assign in_fire  = s_tvalid & s_tready;
    assign out_fire = r_out_valid & m_tready;
    assign s_tready = ~r_skid_valid;
    assign c        = s_tdata;

    assign tok_inc  = (&r_tok_len) ? r_tok_len : r_tok_len + LEN_BITS'(1);
    assign pend_inc = (&r_pend) ? r_pend : r_pend + LEN_BITS'(1);
    assign pend_ext = CMP_W'(r_pend);

    always_comb begin
        case (r_phase)
            PH_METHOD:  limit = r_max_method;
            PH_URI:     limit = r_max_uri;
            PH_VERSION: limit = r_max_version;
            default:    limit = r_max_header;
        endcase
    end

    assign len_ok = CMP_W'(r_tok_len) < CMP_W'(limit);

    // first candidate whose length equals the collected token length
    always_comb begin
        found      = 1'b0;
        found_code = '0;
        for (int m = NUM_METHODS - 1; m >= 0; m--) begin
            if (r_cands[m] && (r_tok_len == LEN_BITS'(METHOD_LEN[m]))) begin
                found      = 1'b1;
                found_code = 3'(m);
            end
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_tok_len      = r_tok_len;
        n_cands        = r_cands;
        n_pend         = r_pend;
        n_in_value     = r_in_value;
        n_skip_sp      = r_skip_sp;
        n_line_content = r_line_content;
        n_err          = r_err;
        res            = '0;

        if (s_tuser) begin
            n_phase        = PH_METHOD;
            n_cands        = '1;
            n_err          = ERR_NONE;
            n_tok_len      = '0;
            n_pend         = '0;
            n_in_value     = 1'b0;
            n_skip_sp      = 1'b0;
            n_line_content = 1'b0;
        end else begin
            case (r_phase)
                PH_METHOD: begin
                    if (c == CH_SP) begin
                        if (found) begin
                            res.event_res   = EV_METHOD;
                            res.method_code = found_code;
                            n_phase         = PH_URI;
                            n_tok_len       = '0;
                            n_cands         = '1;
                        end else begin
                            n_phase = PH_ERROR;
                            n_err   = ERR_METHOD;
                        end
                    end else if (!len_ok) begin
                        n_phase = PH_ERROR;
                        n_err   = ERR_TOO_LONG;
                    end else begin
                        n_tok_len = tok_inc;
                        for (int m = 0; m < NUM_METHODS; m++) begin
                            if (!((r_tok_len < LEN_BITS'(METHOD_LEN[m])) &&
                                  (method_char(3'(m), r_tok_len[2:0]) == c))) begin
                                n_cands[m] = 1'b0;
                            end
                        end
                    end
                end
                PH_URI: begin
                    if (c == CH_SP) begin
                        res.event_res = EV_URI_END;
                        n_phase       = PH_VERSION;
                        n_tok_len     = '0;
                    end else if (!len_ok) begin
                        n_phase = PH_ERROR;
                        n_err   = ERR_TOO_LONG;
                    end else begin
                        n_tok_len     = tok_inc;
                        res.data_kind = KIND_URI;
                        res.data_byte = c;
                    end
                end
                PH_VERSION: begin
                    if (c == CH_LF) begin
                        res.event_res  = EV_VER_END;
                        n_phase        = PH_HEADER;
                        n_tok_len      = '0;
                        n_pend         = '0;
                        n_in_value     = 1'b0;
                        n_skip_sp      = 1'b0;
                        n_line_content = 1'b0;
                    end else if (!len_ok) begin
                        n_phase = PH_ERROR;
                        n_err   = ERR_TOO_LONG;
                    end else if (c == CH_CR) begin
                        n_tok_len = tok_inc;
                        n_pend    = pend_inc;
                    end else begin
                        n_tok_len         = tok_inc;
                        res.data_kind     = KIND_VERSION;
                        res.data_byte     = c;
                        res.held_cr_count = pend_ext[HELD_W-1:0];
                        n_pend            = '0;
                    end
                end
                PH_HEADER: begin
                    if (c == CH_LF) begin
                        if (!r_line_content) begin
                            res.event_res = EV_HEAD_END;
                            n_phase       = PH_DONE;
                        end else if (!r_in_value) begin
                            n_phase = PH_ERROR;
                            n_err   = ERR_NO_COLON;
                        end else begin
                            res.event_res = EV_HDR_END;
                        end
                        if (!(r_line_content && !r_in_value)) begin
                            n_tok_len      = '0;
                            n_pend         = '0;
                            n_in_value     = 1'b0;
                            n_skip_sp      = 1'b0;
                            n_line_content = 1'b0;
                        end
                    end else if (!len_ok) begin
                        n_phase = PH_ERROR;
                        n_err   = ERR_TOO_LONG;
                    end else if (c == CH_CR) begin
                        n_tok_len = tok_inc;
                        n_pend    = pend_inc;
                    end else begin
                        n_tok_len      = tok_inc;
                        n_line_content = 1'b1;
                        if (!r_in_value) begin
                            res.held_cr_count = pend_ext[HELD_W-1:0];
                            n_pend            = '0;
                            if (c == CH_COLON) begin
                                res.event_res = EV_KEY_END;
                                n_in_value    = 1'b1;
                                n_skip_sp     = 1'b1;
                            end else begin
                                res.data_kind = KIND_KEY;
                                res.data_byte = c;
                            end
                        end else if (r_skip_sp && (c == CH_SP) && (r_pend == '0)) begin
                            // leading value space dropped
                        end else begin
                            n_skip_sp         = 1'b0;
                            res.data_kind     = KIND_VALUE;
                            res.data_byte     = c;
                            res.held_cr_count = pend_ext[HELD_W-1:0];
                            n_pend            = '0;
                        end
                    end
                end
                PH_DONE: begin
                    n_phase = PH_ERROR;
                    n_err   = ERR_TRAILING;
                end
                default: begin
                end
            endcase
        end

        res.phase      = n_phase;
        res.error_code = (n_phase == PH_ERROR) ? n_err : ERR_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_method   <= RST_MAX_METHOD;
            r_max_uri      <= RST_MAX_URI;
            r_max_version  <= RST_MAX_VERSION;
            r_max_header   <= RST_MAX_HEADER;
            r_phase        <= PH_METHOD;
            r_tok_len      <= '0;
            r_cands        <= '1;
            r_pend         <= '0;
            r_in_value     <= 1'b0;
            r_skip_sp      <= 1'b0;
            r_line_content <= 1'b0;
            r_err          <= ERR_NONE;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MAX_METHOD:  r_max_method  <= i_cfg_data;
                    CFG_MAX_URI:     r_max_uri     <= i_cfg_data;
                    CFG_MAX_VERSION: r_max_version <= i_cfg_data;
                    CFG_MAX_HEADER:  r_max_header  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                r_phase        <= n_phase;
                r_tok_len      <= n_tok_len;
                r_cands        <= n_cands;
                r_pend         <= n_pend;
                r_in_value     <= n_in_value;
                r_skip_sp      <= n_skip_sp;
                r_line_content <= n_line_content;
                r_err          <= n_err;
            end
            if (r_skid_valid) begin
                if (out_fire) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_fire) begin
                if (!r_out_valid || out_fire) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= res;
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.data_kind;
    assign m_tdata  = {4'b0000, r_out.phase, r_out.error_code, r_out.method_code,
                       r_out.event_res, r_out.held_cr_count, r_out.data_byte};

    // the skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    // a restart always lands the parser back in the method phase with a full mask
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_tuser) |=> (r_phase == PH_METHOD) && (&r_cands) && (r_tok_len == '0))
        else $error("restart did not reset the parser state");

    // an error result always carries a nonzero error code, and only error results do
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.phase == PH_ERROR) == (r_out.error_code != ERR_NONE)))
        else $error("error code does not match the reported phase");

    // the error phase is sticky until a restart
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_ERROR) && !(in_fire && s_tuser)) |=> (r_phase == PH_ERROR))
        else $error("parser left the error phase without a restart");

endmodule

/* bench/http_request_head_parser_core_tb.sv */
// self-checking testbench for the http request head parser core
module http_request_head_parser_core_tb;
    import hrhp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PRINT_CAP   = 40;
    localparam logic [2:0] M_PUT = 3'd6;

    // request budgets per limit setting; setting 0 keeps the reset limits
    localparam int PHASE_ITEMS [6] = '{420, 380, 380, 60, 320, 250};
    localparam logic [CFG_ADDR_W-1:0] LIMIT_REG [4] = '{
        CFG_MAX_METHOD, CFG_MAX_URI, CFG_MAX_VERSION, CFG_MAX_HEADER
    };

    typedef struct {
        bit         act;
        logic [7:0] b;
        bit         typed;
        t_result    want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;   // in_byte
    logic                  s_tuser = 1'b0; // action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // data_byte, held_cr_count, event_res, method_code, error_code, phase, zero pad
    logic [39:0]           m_tdata;
    logic [2:0]            m_tuser;        // data_kind

    http_request_head_parser_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always #4 i_clk = ~i_clk;

    // parser mirror
    string       verb_name [8] = '{"CONNECT", "DELETE", "GET", "HEAD",
                                   "OPTIONS", "POST", "PUT", "TRACE"};
    logic [15:0] lim [4];
    t_phase      ph;
    t_error      err_code;
    logic [15:0] tok_len;
    logic [7:0]  cand;
    logic [15:0] crs;
    bit          in_val, skip_sp, has_content;

    t_result     pending_results [$];
    t_row        steps [$];
    logic [8:0]  msg [$];
    int          sent_items, useful_items, results_seen, mismatch_count;
    int          messages, heads_done, cycle_count, sink_hold;
    int          err_hits [5];
    bit          calm;

    function automatic logic [15:0] next_count(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic void clear_line_state();
        tok_len = '0;
        crs = '0;
        in_val = 1'b0;
        skip_sp = 1'b0;
        has_content = 1'b0;
    endfunction

    function automatic void restart_parser();
        ph = PH_METHOD;
        cand = 8'hFF;
        err_code = ERR_NONE;
        clear_line_state();
    endfunction

    function automatic void set_error(t_error e);
        ph = PH_ERROR;
        err_code = e;
        err_hits[e]++;
    endfunction

    // false when one more byte would exceed the limit
    function automatic bit take_byte(logic [15:0] limit);
        if (tok_len >= limit) return 1'b0;
        tok_len = next_count(tok_len);
        return 1'b1;
    endfunction

    function automatic t_result step_parser(bit act, logic [7:0] c);
        t_result r;
        bit hit;
        r = '0;
        if (act) begin
            restart_parser();
        end else begin
            case (ph)
                PH_METHOD: begin
                    if (c == CH_SP) begin
                        hit = 1'b0;
                        for (int m = 0; m < 8; m++) begin
                            if (!hit && cand[m] && verb_name[m].len() == int'(tok_len)) begin
                                hit = 1'b1;
                                r.method_code = 3'(m);
                            end
                        end
                        if (hit) begin
                            r.event_res = EV_METHOD;
                            ph = PH_URI;
                            tok_len = '0;
                            cand = 8'hFF;
                        end else begin
                            set_error(ERR_METHOD);
                        end
                    end else if (tok_len >= lim[CFG_MAX_METHOD]) begin
                        set_error(ERR_TOO_LONG);
                    end else begin
                        for (int m = 0; m < 8; m++) begin
                            if (!(int'(tok_len) < verb_name[m].len()
                                  && verb_name[m][tok_len] == c))
                                cand[m] = 1'b0;
                        end
                        tok_len = next_count(tok_len);
                    end
                end
                PH_URI: begin
                    if (c == CH_SP) begin
                        r.event_res = EV_URI_END;
                        ph = PH_VERSION;
                        tok_len = '0;
                    end else if (!take_byte(lim[CFG_MAX_URI])) begin
                        set_error(ERR_TOO_LONG);
                    end else begin
                        r.data_kind = KIND_URI;
                        r.data_byte = c;
                    end
                end
                PH_VERSION: begin
                    if (c == CH_LF) begin
                        r.event_res = EV_VER_END;
                        ph = PH_HEADER;
                        clear_line_state();
                    end else if (!take_byte(lim[CFG_MAX_VERSION])) begin
                        set_error(ERR_TOO_LONG);
                    end else if (c == CH_CR) begin
                        crs = next_count(crs);
                    end else begin
                        r.data_kind = KIND_VERSION;
                        r.data_byte = c;
                        r.held_cr_count = crs;
                        crs = '0;
                    end
                end
                PH_HEADER: begin
                    if (c == CH_LF) begin
                        if (!has_content) begin
                            r.event_res = EV_HEAD_END;
                            ph = PH_DONE;
                            clear_line_state();
                            heads_done++;
                        end else if (!in_val) begin
                            set_error(ERR_NO_COLON);
                        end else begin
                            r.event_res = EV_HDR_END;
                            clear_line_state();
                        end
                    end else if (!take_byte(lim[CFG_MAX_HEADER])) begin
                        set_error(ERR_TOO_LONG);
                    end else if (c == CH_CR) begin
                        crs = next_count(crs);
                    end else begin
                        has_content = 1'b1;
                        if (!in_val) begin
                            r.held_cr_count = crs;
                            crs = '0;
                            if (c == CH_COLON) begin
                                r.event_res = EV_KEY_END;
                                in_val = 1'b1;
                                skip_sp = 1'b1;
                            end else begin
                                r.data_kind = KIND_KEY;
                                r.data_byte = c;
                            end
                        // leading value spaces are dropped while no cr is held
                        end else if (!(skip_sp && c == CH_SP && crs == 0)) begin
                            skip_sp = 1'b0;
                            r.data_kind = KIND_VALUE;
                            r.data_byte = c;
                            r.held_cr_count = crs;
                            crs = '0;
                        end
                    end
                end
                PH_DONE: set_error(ERR_TRAILING);
                default: ;
            endcase
        end
        r.error_code = (ph == PH_ERROR) ? err_code : ERR_NONE;
        r.phase = ph;
        return r;
    endfunction

    function automatic t_result bare(t_event ev, logic [2:0] mc, t_error er, t_phase p);
        t_result r;
        r = '0;
        r.event_res = ev;
        r.method_code = mc;
        r.error_code = er;
        r.phase = p;
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] any_byte_but(logic [7:0] a, logic [7:0] b);
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == a || v == b);
        return v;
    endfunction

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at result %0d: %s", results_seen, what);
    endtask

    task automatic add_row(bit act, logic [7:0] b, bit typed = 1'b0, t_result want = '0);
        t_row row;
        row.act = act;
        row.b = b;
        row.typed = typed;
        row.want = want;
        steps.push_back(row);
    endtask

    task automatic push_request(bit act, logic [7:0] b, bit typed, t_result want);
        int gap;
        t_result predicted;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= b;
        do @(posedge i_clk); while (!s_tready);
        if (act || ph != PH_ERROR) useful_items++;
        predicted = step_parser(act, b);
        pending_results.push_back(typed ? want : predicted);
        sent_items++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.data_kind = t_kind'(m_tuser);
            got.data_byte = m_tdata[7:0];
            got.held_cr_count = m_tdata[23:8];
            got.event_res = t_event'(m_tdata[26:24]);
            got.method_code = m_tdata[29:27];
            got.error_code = t_error'(m_tdata[32:30]);
            got.phase = t_phase'(m_tdata[35:33]);
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result %h with nothing pending", got));
            end else begin
                want = pending_results.pop_front();
                if (got.data_kind !== want.data_kind)
                    note_mismatch($sformatf("data_kind %0d, want %0d",
                                            got.data_kind, want.data_kind));
                if (got.data_byte !== want.data_byte)
                    note_mismatch($sformatf("data_byte %h, want %h",
                                            got.data_byte, want.data_byte));
                if (got.held_cr_count !== want.held_cr_count)
                    note_mismatch($sformatf("held_cr_count %0d, want %0d",
                                            got.held_cr_count, want.held_cr_count));
                if (got.event_res !== want.event_res)
                    note_mismatch($sformatf("event_res %0d, want %0d",
                                            got.event_res, want.event_res));
                if (got.method_code !== want.method_code)
                    note_mismatch($sformatf("method_code %0d, want %0d",
                                            got.method_code, want.method_code));
                if (got.error_code !== want.error_code)
                    note_mismatch($sformatf("error_code %0d, want %0d",
                                            got.error_code, want.error_code));
                if (got.phase !== want.phase)
                    note_mismatch($sformatf("phase %0d, want %0d", got.phase, want.phase));
            end
            results_seen++;
        end
        if (sink_hold > 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            sink_hold = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results still pending", pending_results.size());
            $display("FAIL http_request_head_parser_core");
            $finish;
        end
    end

    initial begin
        int len, m, roll, target;
        logic [15:0] lims [4];
        lim[CFG_MAX_METHOD] = RST_MAX_METHOD;
        lim[CFG_MAX_URI] = RST_MAX_URI;
        lim[CFG_MAX_VERSION] = RST_MAX_VERSION;
        lim[CFG_MAX_HEADER] = RST_MAX_HEADER;
        restart_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hand-written request head with every kind of field and event
        add_row(1'b1, 8'hFF, 1'b1, bare(EV_NONE, 3'd0, ERR_NONE, PH_METHOD));
        add_row(1'b0, "P");
        add_row(1'b0, "U");
        add_row(1'b0, "T");
        add_row(1'b0, CH_SP, 1'b1, bare(EV_METHOD, M_PUT, ERR_NONE, PH_URI));
        add_row(1'b0, 8'hFF);
        add_row(1'b0, 8'h00);
        add_row(1'b0, CH_CR);          // cr is a plain uri byte
        add_row(1'b0, CH_SP, 1'b1, bare(EV_URI_END, 3'd0, ERR_NONE, PH_VERSION));
        add_row(1'b0, "H");
        add_row(1'b0, CH_CR);
        add_row(1'b0, CH_CR);
        add_row(1'b0, "1");            // releases both held crs
        add_row(1'b0, CH_CR);
        add_row(1'b0, CH_LF, 1'b1, bare(EV_VER_END, 3'd0, ERR_NONE, PH_HEADER));
        add_row(1'b0, "k");
        add_row(1'b0, CH_COLON, 1'b1, bare(EV_KEY_END, 3'd0, ERR_NONE, PH_HEADER));
        add_row(1'b0, CH_SP);
        add_row(1'b0, CH_SP);
        add_row(1'b0, CH_CR);
        add_row(1'b0, CH_SP);          // space after a cr is value content
        add_row(1'b0, CH_COLON);
        add_row(1'b0, CH_CR);
        add_row(1'b0, CH_LF, 1'b1, bare(EV_HDR_END, 3'd0, ERR_NONE, PH_HEADER));
        add_row(1'b0, CH_CR);
        add_row(1'b0, CH_LF, 1'b1, bare(EV_HEAD_END, 3'd0, ERR_NONE, PH_DONE));
        add_row(1'b0, "x", 1'b1, bare(EV_NONE, 3'd0, ERR_TRAILING, PH_ERROR));
        add_row(1'b1, 8'h00, 1'b1, bare(EV_NONE, 3'd0, ERR_NONE, PH_METHOD));
        add_row(1'b0, CH_SP, 1'b1, bare(EV_NONE, 3'd0, ERR_METHOD, PH_ERROR));
        foreach (steps[i]) push_request(steps[i].act, steps[i].b, steps[i].typed, steps[i].want);

        for (int p = 0; p < 6; p++) begin
            s_tvalid <= 1'b0;
            wait_drained();
            if (p > 0) begin
                case (p)
                    1: lims = '{16'd5, 16'd6, 16'd5, 16'd10};
                    2: lims = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                    3: lims = '{16'd0, 16'd0, 16'd0, 16'd0};
                    4: lims = '{16'($urandom_range(0, 8)), 16'($urandom_range(0, 12)),
                                16'($urandom_range(0, 12)), 16'($urandom_range(0, 16))};
                    default: lims = '{RST_MAX_METHOD, RST_MAX_URI,
                                      RST_MAX_VERSION, RST_MAX_HEADER};
                endcase
                for (int k = 0; k < 4; k++) begin
                    i_cfg_we <= 1'b1;
                    i_cfg_addr <= LIMIT_REG[k];
                    i_cfg_data <= lims[k];
                    lim[LIMIT_REG[k]] = lims[k];
                    @(posedge i_clk);
                end
                i_cfg_we <= 1'b0;
            end
            target = sent_items + PHASE_ITEMS[p];
            while (sent_items < target) begin
                msg.delete();
                calm = ($urandom_range(0, 5) == 0);
                messages++;
                if ($urandom_range(0, 9) == 0) begin
                    // noise: random restarts and bytes
                    repeat ($urandom_range(1, 8))
                        msg.push_back({($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255))});
                end else begin
                    msg.push_back({1'b1, 8'($urandom_range(0, 255))});
                    roll = $urandom_range(0, 19);
                    if (roll < 17) begin
                        m = $urandom_range(0, 7);
                        for (int j = 0; j < verb_name[m].len(); j++)
                            msg.push_back({1'b0, verb_name[m][j]});
                    end else if (roll < 19) begin
                        repeat ($urandom_range(0, 9))
                            msg.push_back({1'b0, 8'($urandom_range(8'h41, 8'h5A))});
                    end else begin
                        repeat ($urandom_range(0, 20))
                            msg.push_back({1'b0, any_byte_but(CH_SP, CH_SP)});
                    end
                    msg.push_back({1'b0, CH_SP});
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
                                                      : $urandom_range(0, 8);
                    repeat (len) msg.push_back({1'b0, any_byte_but(CH_SP, CH_SP)});
                    msg.push_back({1'b0, CH_SP});
                    repeat ($urandom_range(0, 9))
                        msg.push_back({1'b0, ($urandom_range(0, 4) == 0)
                                             ? CH_CR : any_byte_but(CH_LF, CH_CR)});
                    if ($urandom_range(0, 3) != 0) msg.push_back({1'b0, CH_CR});
                    msg.push_back({1'b0, CH_LF});
                    repeat ($urandom_range(0, 3)) begin
                        repeat ($urandom_range(0, 6))
                            msg.push_back({1'b0, ($urandom_range(0, 7) == 0)
                                                 ? CH_CR : any_byte_but(CH_LF, CH_COLON)});
                        // a few header lines lose their colon
                        if ($urandom_range(0, 11) != 0) begin
                            msg.push_back({1'b0, CH_COLON});
                            repeat ($urandom_range(0, 3))
                                msg.push_back({1'b0, ($urandom_range(0, 3) == 0)
                                                     ? CH_CR : CH_SP});
                            repeat ($urandom_range(0, 8)) begin
                                roll = $urandom_range(0, 11);
                                msg.push_back({1'b0, (roll < 2) ? CH_SP : (roll < 4)
                                                     ? CH_CR : any_byte_but(CH_LF, CH_LF)});
                            end
                        end
                        if ($urandom_range(0, 3) != 0) msg.push_back({1'b0, CH_CR});
                        msg.push_back({1'b0, CH_LF});
                    end
                    if ($urandom_range(0, 3) != 0) msg.push_back({1'b0, CH_CR});
                    msg.push_back({1'b0, CH_LF});
                    if ($urandom_range(0, 7) == 0)
                        repeat ($urandom_range(1, 3))
                            msg.push_back({1'b0, 8'($urandom_range(0, 255))});
                    // broken message: cut off somewhere
                    if ($urandom_range(0, 9) == 0) begin
                        len = $urandom_range(1, msg.size());
                        while (msg.size() > len) msg.delete(msg.size() - 1);
                    end
                end
                foreach (msg[k]) push_request(msg[k][8], msg[k][7:0], 1'b0, '0);
                if ($urandom_range(0, 24) == 0) begin
                    s_tvalid <= 1'b0;
                    wait_drained();
                end
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("covered %0d requests (%0d not ignored) in %0d messages over six limit sets,",
                 sent_items, useful_items, messages);
        $display("  %0d heads completed; errors: method %0d, length %0d, colon %0d, trailing %0d",
                 heads_done, err_hits[ERR_METHOD], err_hits[ERR_TOO_LONG],
                 err_hits[ERR_NO_COLON], err_hits[ERR_TRAILING]);
        if (mismatch_count == 0) begin
            $display("PASS http_request_head_parser_core");
        end else begin
            $display("%0d mismatches in %0d results", mismatch_count, results_seen);
            $display("FAIL http_request_head_parser_core");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/hrhp_pkg.sv
hdl/http_request_head_parser_core.sv
bench/http_request_head_parser_core_tb.sv
